/* rtl/sts_pkg.sv */
// Package: shared constants and types for the timer scheduler.
`timescale 1ns / 1ps
package sts_pkg;
    localparam int MAX_TIMERS_DEF = 16;
    localparam logic [15:0] SCAN_PERIOD_RST = 16'd100;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_KILL   = 3'd2,
        OP_FIRE   = 3'd3,
        OP_MAP    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        EV_CREATED   = 3'd0,
        EV_FULL      = 3'd1,
        EV_ENDED     = 3'd2,
        EV_CONTINUES = 3'd3,
        EV_KILLED    = 3'd4,
        EV_NONE      = 3'd5
    } t_ev;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] elapsed;
        logic [3:0]  slot;
        logic [29:0] interval;
        logic        repeat_req;
        logic        kill_on_map_change;
        logic        delay_restart;
    } t_in;

    typedef struct packed {
        logic [2:0] event_res;
        logic [3:0] slot_res;
        logic       last;
    } t_out;
endpackage

/* rtl/sts_if.sv */
// Interface: valid/ready channel carrying one item.
`timescale 1ns / 1ps
interface sts_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport mon (input valid, input data, input ready);
endinterface

/* rtl/sts_out_reg.sv */
// Output register: one-entry skid buffer for result items.
`timescale 1ns / 1ps
module sts_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sts_pkg::t_out    i_data,
    output logic             o_full,
    sts_if.source            o_res
);
    import sts_pkg::*;
    logic r_valid;
    t_out r_data;

    assign o_full      = r_valid;
    assign o_res.valid = r_valid;
    assign o_res.data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
        if (i_push) begin
            r_data <= i_data;
        end
    end
endmodule

/* rtl/software_timer_scheduler.sv */
// Timer scheduler top level: control sequencer, time memory, slot flags.
// Use: items enter on i_cmd (operation and arguments); results leave on o_res,
// each with event_res, slot_res and last (set on an item's final result).
// scan_period is written through i_cfg_we/i_cfg_wdata; the user must write it
// only while idle, the block does not enforce it. One item at a time. A tick
// without scan goes through setup only; create and kill go through setup and
// the single-result state; fire-now adds a memory wait state between them. A
// tick with scan or a map change does selection passes: each pass walks all
// MAX_TIMERS slots through the due/period memory, one read a cycle unless the
// repeat pass is held. Setup comes first; the one-shot pass runs once per
// one-shot removed plus once, then the repeat pass once, then finish. The
// repeat pass holds while the output register is busy. The final result is
// held in a register so that last can be set on it.
// Reset empties the table and clears time; memory contents need no clearing.
// When the receiver stalls the sequencer waits on the full output register;
// i_cmd ready returns as the item's final result, if any, is pushed to it.
`timescale 1ns / 1ps
module software_timer_scheduler #(
    parameter int MAX_TIMERS = sts_pkg::MAX_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    sts_if.sink         i_cmd,
    sts_if.source       o_res
);
    import sts_pkg::*;
    localparam int SW = $clog2(MAX_TIMERS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_EMIT  = 7'b0001000,
        S_FWAIT = 7'b0010000,
        S_SINGL = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_st;

    t_st r_st;
    logic [15:0] r_scan_period;
    logic [MAX_TIMERS-1:0] r_valid, r_rep, r_mk;
    logic [31:0] r_due [MAX_TIMERS];
    logic [29:0] r_per [MAX_TIMERS];
    logic [31:0] r_due_q;
    logic [29:0] r_per_q;
    logic [31:0] r_now, r_last_scan;
    t_in r_cmd;
    // phase 0: one-shot selection, phase 1: repeat walk
    logic r_phase;
    logic [SW:0] r_idx;
    logic [SW-1:0] r_rd_idx;
    logic r_rd_vld;
    logic r_found;
    logic [SW-1:0] r_best;
    logic [31:0] r_best_age;
    logic [3:0] r_sing_slot;
    logic [2:0] r_sing_ev;
    logic r_out_push;
    t_out r_out_data;
    // newest result of a walk, held until the next one shows it is not last
    logic r_pv;
    t_out r_pd;
    logic out_full;
    logic out_busy;
    logic walk_go;

    sts_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (r_out_push),
        .i_data (r_out_data),
        .o_full (out_full),
        .o_res  (o_res)
    );

    assign i_cmd.ready = (r_st == S_IDLE);
    assign out_busy    = out_full || r_out_push;
    assign walk_go     = !(r_phase && out_busy);

    logic [SW-1:0] rd_addr;
    logic          we;
    logic [SW-1:0] wr_addr;
    logic [31:0]   wr_due;
    logic [29:0]   wr_per;
    logic          wr_per_en;

    always_ff @(posedge i_clk) begin
        r_due_q <= r_due[rd_addr];
        r_per_q <= r_per[rd_addr];
        if (we) begin
            r_due[wr_addr] <= wr_due;
            if (wr_per_en) begin
                r_per[wr_addr] <= wr_per;
            end
        end
    end

    logic [31:0] age;
    logic        due_ok;
    logic [SW-1:0] first_free;
    logic          any_free;
    logic [SW-1:0] cslot;
    logic          slot_in;
    logic          known;
    logic [31:0]   since;

    assign age    = (r_now - r_due_q) ^ 32'h8000_0000;
    assign due_ok = age[31];
    assign cslot  = SW'(r_cmd.slot);
    assign slot_in = ({28'b0, r_cmd.slot} < 32'(MAX_TIMERS));
    assign known  = slot_in && r_valid[cslot];
    assign since  = r_now - r_last_scan;

    always_comb begin
        first_free = '0;
        any_free = 1'b0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                first_free = SW'(i);
                any_free = 1'b1;
            end
        end
    end

    // memory access mux; a held walk re-reads the entry under test
    always_comb begin
        rd_addr = r_idx[SW-1:0];
        if (r_st == S_IDLE || r_st == S_SETUP) begin
            rd_addr = cslot;
        end else if (r_st == S_WALK && !walk_go) begin
            rd_addr = r_rd_idx;
        end
        we = 1'b0;
        wr_addr = r_rd_idx;
        wr_due = r_now + {2'b0, r_per_q};
        wr_per = r_cmd.interval;
        wr_per_en = 1'b0;
        if (r_st == S_SETUP && t_op'(r_cmd.operation) == OP_CREATE && any_free) begin
            we = 1'b1;
            wr_addr = first_free;
            wr_due = r_now + {2'b0, r_cmd.interval};
            wr_per_en = 1'b1;
        end else if (r_st == S_FWAIT && r_cmd.delay_restart && known && r_rep[cslot]) begin
            we = 1'b1;
            wr_addr = cslot;
        end else if (r_st == S_WALK && r_phase && r_rd_vld && !r_cmd.operation[2]
                     && r_valid[r_rd_idx] && r_rep[r_rd_idx] && due_ok && !out_busy) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_scan_period <= SCAN_PERIOD_RST;
            r_valid <= '0;
            r_rep <= '0;
            r_mk <= '0;
            r_now <= '0;
            r_last_scan <= '0;
            r_out_push <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_out_push <= 1'b0;
            if (i_cfg_we) begin
                r_scan_period <= i_cfg_wdata;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd <= i_cmd.data;
                        r_st <= S_SETUP;
                        if (t_op'(i_cmd.data.operation) == OP_TICK) begin
                            r_now <= r_now + {16'b0, i_cmd.data.elapsed};
                        end
                    end
                end
                S_SETUP: begin
                    r_phase <= 1'b0;
                    r_idx <= '0;
                    r_rd_vld <= 1'b0;
                    r_found <= 1'b0;
                    unique case (r_cmd.operation)
                        OP_TICK: begin
                            if (!since[31] && since >= {16'b0, r_scan_period}) begin
                                r_last_scan <= r_now;
                                r_st <= S_WALK;
                            end else begin
                                r_st <= S_IDLE;
                            end
                        end
                        OP_CREATE: begin
                            if (any_free) begin
                                r_valid[first_free] <= 1'b1;
                                r_rep[first_free] <= r_cmd.repeat_req;
                                r_mk[first_free] <= r_cmd.kill_on_map_change;
                                r_sing_ev <= EV_CREATED;
                                r_sing_slot <= 4'(first_free);
                            end else begin
                                r_sing_ev <= EV_FULL;
                                r_sing_slot <= '0;
                            end
                            r_st <= S_SINGL;
                        end
                        OP_KILL: begin
                            r_sing_slot <= r_cmd.slot;
                            if (known) begin
                                r_valid[cslot] <= 1'b0;
                                r_sing_ev <= EV_KILLED;
                            end else begin
                                r_sing_ev <= EV_NONE;
                            end
                            r_st <= S_SINGL;
                        end
                        OP_FIRE: begin
                            r_st <= S_FWAIT;
                        end
                        OP_MAP: begin
                            r_st <= S_WALK;
                        end
                        default: r_st <= S_IDLE;
                    endcase
                end
                S_FWAIT: begin
                    // memory data for cslot is valid here
                    r_sing_slot <= r_cmd.slot;
                    if (!known) begin
                        r_sing_ev <= EV_NONE;
                    end else if (!r_rep[cslot]) begin
                        r_valid[cslot] <= 1'b0;
                        r_sing_ev <= EV_ENDED;
                    end else begin
                        r_sing_ev <= EV_CONTINUES;
                    end
                    r_st <= S_SINGL;
                end
                S_SINGL: begin
                    if (!out_busy) begin
                        r_out_push <= 1'b1;
                        r_out_data <= '{event_res: r_sing_ev, slot_res: r_sing_slot,
                                        last: 1'b1};
                        r_st <= S_IDLE;
                    end
                end
                S_WALK: begin
                    // hold the repeat walk while the output register is busy
                    if (walk_go) begin
                        r_rd_vld <= (r_idx < (SW+1)'(MAX_TIMERS));
                        r_rd_idx <= r_idx[SW-1:0];
                        if (r_idx < (SW+1)'(MAX_TIMERS)) begin
                            r_idx <= r_idx + (SW+1)'(1);
                        end
                        if (r_rd_vld) begin
                            if (!r_phase) begin
                                if (r_valid[r_rd_idx] && !r_rep[r_rd_idx]
                                    && (r_cmd.operation[2] ? r_mk[r_rd_idx] : due_ok)
                                    && (!r_found || age > r_best_age)) begin
                                    r_found <= 1'b1;
                                    r_best <= r_rd_idx;
                                    r_best_age <= age;
                                end
                            end else if (r_valid[r_rd_idx] && r_rep[r_rd_idx]
                                         && (r_cmd.operation[2] ? r_mk[r_rd_idx] : due_ok)) begin
                                if (r_cmd.operation[2]) begin
                                    r_valid[r_rd_idx] <= 1'b0;
                                end
                                if (r_pv) begin
                                    r_out_push <= 1'b1;
                                    r_out_data <= r_pd;
                                end
                                r_pv <= 1'b1;
                                r_pd <= '{event_res: r_cmd.operation[2] ? EV_KILLED
                                                                       : EV_CONTINUES,
                                          slot_res: 4'(r_rd_idx), last: 1'b0};
                            end
                        end else if (r_idx == (SW+1)'(MAX_TIMERS)) begin
                            r_st <= r_phase ? S_FIN : S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!out_busy) begin
                        r_idx <= '0;
                        r_rd_vld <= 1'b0;
                        r_found <= 1'b0;
                        r_st <= S_WALK;
                        if (r_found) begin
                            r_valid[r_best] <= 1'b0;
                            if (r_pv) begin
                                r_out_push <= 1'b1;
                                r_out_data <= r_pd;
                            end
                            r_pv <= 1'b1;
                            r_pd <= '{event_res: r_cmd.operation[2] ? EV_KILLED : EV_ENDED,
                                      slot_res: 4'(r_best), last: 1'b0};
                        end else begin
                            r_phase <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    // the held result is the item's final one
                    if (!r_pv) begin
                        r_st <= S_IDLE;
                    end else if (!out_busy) begin
                        r_out_push <= 1'b1;
                        r_out_data <= '{event_res: r_pd.event_res, slot_res: r_pd.slot_res,
                                        last: 1'b1};
                        r_pv <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* tb/timer_checker.sv */
// Checker: predicts timer table results from accepted items and compares them.
`timescale 1ns / 1ps
module timer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    sts_if.mon          cmd_mon,
    sts_if.mon          res_mon,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    import sts_pkg::*;

    localparam int NT = MAX_TIMERS_DEF;

    logic [15:0] period_reg;
    logic        tm_valid [NT];
    logic        tm_rep   [NT];
    logic        tm_mapk  [NT];
    logic [31:0] tm_due   [NT];
    logic [29:0] tm_per   [NT];
    logic [31:0] now_ms;
    logic [31:0] scan_ms;
    t_out        expected_q[$];

    assign o_pending = expected_q.size();

    function automatic bit timer_due(int s);
        logic [31:0] d;
        d = now_ms - tm_due[s];
        return !d[31];
    endfunction

    task automatic push_event(t_ev ev, int s);
        t_out r;
        r.event_res = ev;
        r.slot_res  = s[3:0];
        r.last      = 1'b0;
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic drain_shots(bit by_map, t_ev ev);
        int best;
        logic [31:0] best_age, age;
        forever begin
            best = -1;
            best_age = '0;
            for (int s = 0; s < NT; s++) begin
                if (!tm_valid[s] || tm_rep[s]) continue;
                if (by_map ? !tm_mapk[s] : !timer_due(s)) continue;
                age = (now_ms - tm_due[s]) ^ 32'h8000_0000;
                if (best < 0 || age > best_age) begin
                    best = s;
                    best_age = age;
                end
            end
            if (best < 0) break;
            tm_valid[best] = 1'b0;
            push_event(ev, best);
        end
    endtask

    task automatic predict_item(t_in it);
        int n0, s;
        logic [31:0] d;
        n0 = expected_q.size();
        case (it.operation)
            OP_TICK: begin
                now_ms = now_ms + 32'(it.elapsed);
                d = now_ms - scan_ms;
                if (!d[31] && d >= 32'(period_reg)) begin
                    drain_shots(1'b0, EV_ENDED);
                    for (int k = 0; k < NT; k++) begin
                        if (tm_valid[k] && tm_rep[k] && timer_due(k)) begin
                            push_event(EV_CONTINUES, k);
                            tm_due[k] = now_ms + 32'(tm_per[k]);
                        end
                    end
                    scan_ms = now_ms;
                end
            end
            OP_CREATE: begin
                for (s = 0; s < NT; s++) if (!tm_valid[s]) break;
                if (s >= NT) push_event(EV_FULL, 0);
                else begin
                    tm_valid[s] = 1'b1;
                    tm_rep[s]   = it.repeat_req;
                    tm_mapk[s]  = it.kill_on_map_change;
                    tm_per[s]   = it.interval;
                    tm_due[s]   = now_ms + 32'(it.interval);
                    push_event(EV_CREATED, s);
                end
            end
            OP_KILL: begin
                if (!tm_valid[it.slot]) push_event(EV_NONE, it.slot);
                else begin
                    tm_valid[it.slot] = 1'b0;
                    push_event(EV_KILLED, it.slot);
                end
            end
            OP_FIRE: begin
                if (!tm_valid[it.slot]) push_event(EV_NONE, it.slot);
                else if (!tm_rep[it.slot]) begin
                    tm_valid[it.slot] = 1'b0;
                    push_event(EV_ENDED, it.slot);
                end else begin
                    if (it.delay_restart) tm_due[it.slot] = now_ms + 32'(tm_per[it.slot]);
                    push_event(EV_CONTINUES, it.slot);
                end
            end
            OP_MAP: begin
                drain_shots(1'b1, EV_KILLED);
                for (int k = 0; k < NT; k++) begin
                    if (tm_valid[k] && tm_rep[k] && tm_mapk[k]) begin
                        tm_valid[k] = 1'b0;
                        push_event(EV_KILLED, k);
                    end
                end
            end
            default: ;
        endcase
        if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_out got, want;
        if (!i_rst_n) begin
            period_reg <= SCAN_PERIOD_RST;
            for (int s = 0; s < NT; s++) begin
                tm_valid[s] = 1'b0;
                tm_rep[s]   = 1'b0;
                tm_mapk[s]  = 1'b0;
                tm_due[s]   = '0;
                tm_per[s]   = '0;
            end
            now_ms  = '0;
            scan_ms = '0;
            expected_q.delete();
            o_fail_count   <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_we) period_reg <= i_cfg_wdata;
            if (res_mon.valid && res_mon.ready) begin
                got = res_mon.data;
                o_results_seen <= o_results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result ev=%0d slot=%0d", got.event_res, got.slot_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $error("event_res expected %0d actual %0d",
                               want.event_res, got.event_res);
                        o_fail_count <= o_fail_count + 1;
                    end else if (got.slot_res !== want.slot_res) begin
                        $error("slot_res expected %0d actual %0d",
                               want.slot_res, got.slot_res);
                        o_fail_count <= o_fail_count + 1;
                    end else if (got.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (cmd_mon.valid && cmd_mon.ready) predict_item(cmd_mon.data);
        end
    end
endmodule

/* tb/testbench.sv */
// Testbench top: drives the timer scheduler and reports the verdict.
`timescale 1ns / 1ps
module testbench;
    import sts_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    int          fail_count, pending, results_seen;
    int          items_sent;
    bit          sink_hold;

    sts_if #(.T(t_in))  cmd_ch ();
    sts_if #(.T(t_out)) res_ch ();

    software_timer_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_cmd(cmd_ch.sink), .o_res(res_ch.source)
    );

    timer_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .cmd_mon(cmd_ch.mon), .res_mon(res_ch.mon),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // receiver stalls
    initial begin
        int g;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                g = gap_len();
                res_ch.ready <= (g == 0);
                repeat (g) @(posedge i_clk);
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_in it);
        int g;
        g = gap_len();
        if (g > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cmd_ch.data  <= it;
        cmd_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_period(logic [15:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in make_item(t_op op, logic [15:0] el, logic [3:0] sl,
                                      logic [29:0] iv, bit rp, bit mk, bit dr);
        t_in it;
        it.operation = op;
        it.elapsed = el;
        it.slot = sl;
        it.interval = iv;
        it.repeat_req = rp;
        it.kill_on_map_change = mk;
        it.delay_restart = dr;
        return it;
    endfunction

    function automatic t_in rand_item();
        t_in it;
        logic [63:0] raw;
        int r;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in)-1:0];
        r = $urandom_range(0, 99);
        if (r < 40) it.operation = OP_TICK;
        else if (r < 65) it.operation = OP_CREATE;
        else if (r < 78) it.operation = OP_KILL;
        else if (r < 90) it.operation = OP_FIRE;
        else if (r < 96) it.operation = OP_MAP;
        else it.operation = 3'($urandom_range(5, 7));
        if (it.operation == OP_TICK && $urandom_range(0, 9) != 0)
            it.elapsed = 16'($urandom_range(0, 300));
        if (it.operation == OP_CREATE && $urandom_range(0, 9) != 0)
            it.interval = 30'($urandom_range(0, 2000));
        return it;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        sink_hold = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_item(make_item(OP_TICK, 16'd100, 4'd0, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_CREATE, 16'hFFFF, 4'hF, 30'd50, 1'b0, 1'b1, 1'b0));
        send_item(make_item(OP_CREATE, 16'd0, 4'd0, 30'd50, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_CREATE, 16'd0, 4'd0, 30'd20, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_CREATE, 16'd0, 4'd0, 30'd30, 1'b1, 1'b1, 1'b0));
        send_item(make_item(OP_CREATE, 16'd0, 4'd0, 30'h3FFF_FFFF, 1'b1, 1'b0, 1'b0));
        send_item(make_item(OP_CREATE, 16'd0, 4'd0, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, 16'd99, 4'd0, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, 16'd1, 4'd0, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_FIRE, 16'd0, 4'd3, 30'd0, 1'b0, 1'b0, 1'b1));
        send_item(make_item(OP_FIRE, 16'd0, 4'd4, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_FIRE, 16'd0, 4'd9, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_KILL, 16'd0, 4'hF, 30'd0, 1'b0, 1'b0, 1'b0));
        for (int k = 0; k < 14; k++)
            send_item(make_item(OP_CREATE, 16'd0, 4'd0, 30'(k * 7), k[0], k[1], 1'b0));
        send_item(make_item(OP_MAP, 16'd0, 4'd0, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(t_op'(3'd7), 16'd0, 4'd0, 30'd0, 1'b0, 1'b0, 1'b0));
        send_item(make_item(OP_TICK, 16'hFFFF, 4'd0, 30'd0, 1'b0, 1'b0, 1'b0));

        write_period(16'd0);
        for (int k = 0; k < 50; k++) begin
            if (k == 25) begin
                sink_hold = 1'b1;
                wait_idle();
                sink_hold = 1'b0;
            end
            send_item(rand_item());
        end
        write_period(16'hFFFF);
        for (int k = 0; k < 30; k++) send_item(rand_item());
        write_period(16'($urandom_range(1, 200)));
        for (int k = 0; k < 60; k++) send_item(rand_item());

        wait_idle();
        $display("covered %0d items, %0d results, scan periods 0, 65535, random",
                 items_sent, results_seen);
        if (fail_count == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
